[design/bee_pkg.sv]
// Shared constants and widths for the byte entropy estimator.
`default_nettype none

package bee_pkg;

  localparam int BYTE_W      = 8;
  localparam int SYMBOLS     = 256;
  localparam int SYM_W       = $clog2(SYMBOLS);
  localparam int BLOCK_MAX   = 65536;
  localparam int CNT_W       = 17;
  localparam int FRAC_BITS   = 24;
  localparam int LOG_INT_W   = 5;
  localparam int LOG_W       = LOG_INT_W + FRAC_BITS;
  localparam int MANT_W      = 31;
  localparam int PROD_W      = CNT_W + LOG_W;
  localparam int ACC_W       = 48;
  localparam int Q_W         = 21;
  localparam int ROUND_SH    = 7;
  localparam int DEN_SH      = 8;
  localparam int DEN_W       = CNT_W + DEN_SH;
  localparam int ENT_W       = 20;
  localparam int STEP_W      = 5;

  localparam logic [ENT_W-1:0] ENTROPY_MAX  = ENT_W'(524288);
  localparam logic [ENT_W-1:0] THRESH_RESET = ENT_W'(471859);

endpackage

`default_nettype wire

[design/byte_entropy_estimator_core.sv]
// Top level: byte histogram in RAM, entropy reduction sequencer and output register.
`default_nettype none

// Bytes of a block are taken one per cycle; each does a read-modify-write of
// its histogram bin in a 256 x 17 RAM (registered read, back-to-back hits on
// the same bin forwarded). On the byte flagged last the input stalls while
// the block is reduced: one log2 of the byte count, then a sweep of all 256
// bins, each read and checked, with each bin holding two or more bytes also
// passing through the 24-step log2 unit and the multiply, then a 21-step
// divide. The stall also lasts through any wait for the previous result to
// be taken. The result waits in an output register, so the next block's
// bytes flow while it is unread. Bin contents need no clearing pass: a valid
// flag per bin is reset at once.
module byte_entropy_estimator_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [bee_pkg::BYTE_W-1:0]  in_byte_value,
  input  wire logic                        in_last,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [bee_pkg::ENT_W-1:0]   out_entropy_q16,
  output logic                             out_above_threshold,
  output logic      [bee_pkg::CNT_W-1:0]   out_byte_count,
  output logic                             out_overflow,
  input  wire logic                        cfg_we,
  input  wire logic [bee_pkg::ENT_W-1:0]   cfg_wdata
);
  import bee_pkg::*;

  localparam logic [3:0] ST_RUN   = 4'd0;
  localparam logic [3:0] ST_FLUSH = 4'd1;
  localparam logic [3:0] ST_NLOG  = 4'd2;
  localparam logic [3:0] ST_NMUL  = 4'd3;
  localparam logic [3:0] ST_RD    = 4'd4;
  localparam logic [3:0] ST_CHK   = 4'd5;
  localparam logic [3:0] ST_BLOG  = 4'd6;
  localparam logic [3:0] ST_BMUL  = 4'd7;
  localparam logic [3:0] ST_BACC  = 4'd8;
  localparam logic [3:0] ST_DIFF  = 4'd9;
  localparam logic [3:0] ST_DIVS  = 4'd10;
  localparam logic [3:0] ST_DIVW  = 4'd11;
  localparam logic [3:0] ST_DONE  = 4'd12;

  logic [3:0]          state_r, state_nxt;
  logic [ENT_W-1:0]    thresh_r;
  logic [CNT_W-1:0]    total_r;
  logic                ovf_r;
  logic [SYMBOLS-1:0]  hist_vld_r;

  logic                s1_vld_r;
  logic [SYM_W-1:0]    s1_addr_r;
  logic                fwd_vld_r;
  logic [SYM_W-1:0]    fwd_addr_r;
  logic [CNT_W-1:0]    fwd_data_r;

  logic [SYM_W-1:0]    idx_r;
  logic [CNT_W-1:0]    c_r;
  logic [ACC_W-1:0]    whole_r;
  logic [ACC_W-1:0]    prod_r;
  logic [ACC_W-1:0]    sum_r;
  logic [ACC_W-1:0]    t_r;

  logic                out_vld_r;
  logic [ENT_W-1:0]    out_ent_r;
  logic                out_above_r;
  logic [CNT_W-1:0]    out_cnt_r;
  logic                out_ovf_r;

  logic                in_acc;
  logic                full;
  logic                count_ok;
  logic [SYM_W-1:0]    sym;
  logic                ram_re;
  logic [SYM_W-1:0]    ram_raddr;
  logic [CNT_W-1:0]    ram_rdata;
  logic [CNT_W-1:0]    old_cnt;
  logic [CNT_W-1:0]    new_cnt;
  logic [CNT_W-1:0]    bin_cnt;
  logic                bin_last;

  logic                log_start;
  logic [CNT_W-1:0]    log_x;
  logic                log_done;
  logic [LOG_W-1:0]    log_res;
  logic [CNT_W-1:0]    mul_a;
  logic [PROD_W-1:0]   mul_p;

  logic                div_start;
  logic [ACC_W-1:0]    div_num;
  logic [DEN_W-1:0]    div_den;
  logic                div_done;
  logic [Q_W-1:0]      div_q;
  logic [ENT_W-1:0]    ent_sat;
  logic                out_load;

  assign in_stall = (state_r != ST_RUN);
  assign in_acc   = in_valid && !in_stall;
  assign full     = (total_r == CNT_W'(BLOCK_MAX));
  assign count_ok = in_acc && !full;
  assign sym      = ({1'b0, in_byte_value} >= (BYTE_W + 1)'(SYMBOLS)) ?
                    SYM_W'(SYMBOLS - 1) : SYM_W'(in_byte_value);

  assign ram_re    = count_ok || (state_r == ST_RD);
  assign ram_raddr = (state_r == ST_RD) ? idx_r : sym;

  // bin that was just written is forwarded; bins never written read as zero
  assign old_cnt = (fwd_vld_r && (fwd_addr_r == s1_addr_r)) ? fwd_data_r :
                   (hist_vld_r[s1_addr_r] ? ram_rdata : '0);
  assign new_cnt = old_cnt + 1'b1;

  assign bin_cnt  = hist_vld_r[idx_r] ? ram_rdata : '0;
  assign bin_last = (idx_r == SYM_W'(SYMBOLS - 1));

  bee_ram #(
    .WIDTH (CNT_W),
    .DEPTH (SYMBOLS)
  ) u_hist (
    .clk   (clk),
    .we    (s1_vld_r),
    .waddr (s1_addr_r),
    .wdata (new_cnt),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign log_start = (state_r == ST_FLUSH) || ((state_r == ST_CHK) && (bin_cnt > CNT_W'(1)));
  assign log_x     = (state_r == ST_FLUSH) ? total_r : bin_cnt;

  bee_log2 u_log (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (log_start),
    .x      (log_x),
    .done   (log_done),
    .result (log_res)
  );

  assign mul_a = (state_r == ST_NMUL) ? total_r : c_r;
  assign mul_p = PROD_W'(mul_a) * PROD_W'(log_res);

  assign div_start = (state_r == ST_DIVS);
  assign div_num   = t_r + (ACC_W'(total_r) << ROUND_SH);
  assign div_den   = DEN_W'(total_r) << DEN_SH;

  bee_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  assign ent_sat  = (div_q > Q_W'(ENTROPY_MAX)) ? ENTROPY_MAX : div_q[ENT_W-1:0];
  assign out_load = (state_r == ST_DONE) && (!out_vld_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUN:   if (in_acc && in_last) state_nxt = ST_FLUSH;
      ST_FLUSH: state_nxt = ST_NLOG;
      ST_NLOG:  if (log_done) state_nxt = ST_NMUL;
      ST_NMUL:  state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_CHK;
      ST_CHK: begin
        if (bin_cnt > CNT_W'(1)) begin
          state_nxt = ST_BLOG;
        end else begin
          state_nxt = bin_last ? ST_DIFF : ST_RD;
        end
      end
      ST_BLOG:  if (log_done) state_nxt = ST_BMUL;
      ST_BMUL:  state_nxt = ST_BACC;
      ST_BACC:  state_nxt = bin_last ? ST_DIFF : ST_RD;
      ST_DIFF:  state_nxt = ST_DIVS;
      ST_DIVS:  state_nxt = ST_DIVW;
      ST_DIVW:  if (div_done) state_nxt = ST_DONE;
      ST_DONE:  if (out_load) state_nxt = ST_RUN;
      default:  state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_RUN;
      thresh_r   <= THRESH_RESET;
      total_r    <= '0;
      ovf_r      <= 1'b0;
      hist_vld_r <= '0;
      s1_vld_r   <= 1'b0;
      fwd_vld_r  <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      s1_vld_r <= count_ok;
      if (cfg_we) begin
        thresh_r <= cfg_wdata;
      end
      if (in_acc) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          total_r <= total_r + 1'b1;
        end
      end
      if (s1_vld_r) begin
        hist_vld_r[s1_addr_r] <= 1'b1;
        fwd_vld_r             <= 1'b1;
      end
      if (out_load) begin
        out_vld_r  <= 1'b1;
        total_r    <= '0;
        ovf_r      <= 1'b0;
        hist_vld_r <= '0;
        fwd_vld_r  <= 1'b0;
      end else if (out_vld_r && !out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (count_ok) begin
      s1_addr_r <= sym;
    end
    if (s1_vld_r) begin
      fwd_addr_r <= s1_addr_r;
      fwd_data_r <= new_cnt;
    end
    if (state_r == ST_FLUSH) begin
      idx_r <= '0;
      sum_r <= '0;
    end
    if (state_r == ST_NMUL) begin
      whole_r <= ACC_W'(mul_p);
    end
    if (state_r == ST_CHK) begin
      c_r <= bin_cnt;
    end
    if (state_r == ST_BMUL) begin
      prod_r <= ACC_W'(mul_p);
    end
    if (state_r == ST_BACC) begin
      sum_r <= sum_r + prod_r;
    end
    if (((state_r == ST_CHK) && (bin_cnt <= CNT_W'(1))) || (state_r == ST_BACC)) begin
      idx_r <= idx_r + 1'b1;
    end
    if (state_r == ST_DIFF) begin
      t_r <= (whole_r > sum_r) ? whole_r - sum_r : '0;
    end
    if (out_load) begin
      out_ent_r   <= ent_sat;
      out_above_r <= (ent_sat >= thresh_r);
      out_cnt_r   <= total_r;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_entropy_q16     = out_ent_r;
  assign out_above_threshold = out_above_r;
  assign out_byte_count      = out_cnt_r;
  assign out_overflow        = out_ovf_r;

endmodule

`default_nettype wire

[design/bee_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module bee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/bee_log2.sv]
// Iterative log2 unit: Q.24 result by repeated squaring, one square per cycle.
`default_nettype none

module bee_log2 (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [bee_pkg::CNT_W-1:0]  x,
  output logic                            done,
  output logic      [bee_pkg::LOG_W-1:0]  result
);
  import bee_pkg::*;

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [STEP_W-1:0]      cnt_r, cnt_nxt;
  logic [MANT_W-1:0]      m_r, m_nxt;
  logic [FRAC_BITS-1:0]   frac_r, frac_nxt;
  logic [LOG_INT_W-1:0]   k_r, k_nxt;

  logic [LOG_INT_W-1:0]   k_in;
  logic [2*MANT_W-1:0]    sq;
  logic [MANT_W:0]        sq_top;

  // index of the top set bit
  always_comb begin
    k_in = '0;
    for (int i = 1; i < CNT_W; i++) begin
      if (x[i]) begin
        k_in = LOG_INT_W'(i);
      end
    end
  end

  assign sq     = (2*MANT_W)'(m_r) * (2*MANT_W)'(m_r);
  assign sq_top = sq[2*MANT_W-1:MANT_W-1];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    m_nxt    = m_r;
    frac_nxt = frac_r;
    k_nxt    = k_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      k_nxt    = k_in;
      frac_nxt = '0;
      m_nxt    = MANT_W'(x) << (LOG_INT_W'(MANT_W - 1) - k_in);
    end else if (busy_r) begin
      // square >= 2.0 yields a one bit and renormalizes
      frac_nxt = {frac_r[FRAC_BITS-2:0], sq_top[MANT_W]};
      m_nxt    = sq_top[MANT_W] ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == STEP_W'(FRAC_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    m_r    <= m_nxt;
    frac_r <= frac_nxt;
    k_r    <= k_nxt;
  end

  assign done   = done_r;
  assign result = {k_r, frac_r};

endmodule

`default_nettype wire

[design/bee_div.sv]
// Restoring divider, one quotient bit per cycle, for the final normalization.
`default_nettype none

module bee_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [bee_pkg::ACC_W-1:0] num,
  input  wire logic [bee_pkg::DEN_W-1:0] den,
  output logic                           done,
  output logic      [bee_pkg::Q_W-1:0]   quot
);
  import bee_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [ACC_W-1:0]  rem_r, rem_nxt;
  logic [ACC_W-1:0]  dsh_r, dsh_nxt;
  logic [Q_W-1:0]    q_r, q_nxt;
  logic              fits;

  assign fits = rem_r >= dsh_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = num;
      // quotient is known to fit in Q_W bits
      dsh_nxt  = ACC_W'(den) << (Q_W - 1);
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? rem_r - dsh_r : rem_r;
      q_nxt   = {q_r[Q_W-2:0], fits};
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == STEP_W'(Q_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

`default_nettype wire

[design/bee_checker.sv]
// Port-level checker for the entropy estimator, bound to the top level.
`default_nettype none

module bee_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [bee_pkg::ENT_W-1:0]  out_entropy_q16,
  input wire logic                       out_above_threshold,
  input wire logic [bee_pkg::CNT_W-1:0]  out_byte_count,
  input wire logic                       out_overflow
);
  import bee_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_entropy_q16) &&
      $stable(out_above_threshold) && $stable(out_byte_count) && $stable(out_overflow))
    else $error("result word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_count != '0) && (out_byte_count <= CNT_W'(BLOCK_MAX)))
    else $error("byte count out of range");

  a_entropy_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entropy_q16 <= ENTROPY_MAX)
    else $error("entropy above 8.0");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_byte_count == CNT_W'(BLOCK_MAX))
    else $error("overflow flagged on a short block");

endmodule

bind byte_entropy_estimator_core bee_checker u_bee_checker (.*);

`default_nettype wire
